// File: rtl/skf_pkg.sv
// Shared constants and register codes for the scalar Kalman estimator.
// No dependencies; every other file of the block imports this package.
package skf_pkg;

    localparam int SKF_FRAC_BITS = 16;
    localparam int DATA_W        = 32;
    localparam int CFG_IDX_W     = 8;

    localparam logic [CFG_IDX_W-1:0] REG_INIT_EST  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_INIT_VAR  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SENS_NOISE = CFG_IDX_W'(3);

    localparam logic [DATA_W-1:0] RST_INIT_EST   = 32'd3276800;
    localparam logic [DATA_W-1:0] RST_INIT_VAR   = 32'd65536;
    localparam logic [DATA_W-1:0] RST_PROC_NOISE = 32'd655;
    localparam logic [DATA_W-1:0] RST_SENS_NOISE = 32'd65536;

endpackage

// File: rtl/scalar_kalman_estimator_top.sv
// Top level of the scalar Kalman estimator: sequencer, state and registers.
// Depends on skf_pkg, skf_div and skf_mul.
//
//  Channel      Direction  Handshake                     Payload
//  measurement  in         i_meas_valid / o_meas_ready   i_measurement
//  estimate     out        o_est_valid  / i_est_ready    o_estimate
//  config       in         i_cfg_valid  / o_cfg_ready    i_cfg_index, i_cfg_data
//
// A request is accepted only while the sequencer is idle, so a new one is not taken
// before the last one is through, and its estimate turns valid once the variance step
// loads it. Most of the work is done by the serial divider that produces one gain bit per cycle.
// Reset is synchronous and loads the default registers, estimate and variance.
// A finished estimate waits in the output register while the next request is
// taken; the block holds its last step only when that register is still full.
module scalar_kalman_estimator_top #(
    parameter int FRAC_BITS = skf_pkg::SKF_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_meas_valid,
    output logic                              o_meas_ready,
    input  logic signed [skf_pkg::DATA_W-1:0] i_measurement,
    output logic                              o_est_valid,
    input  logic                              i_est_ready,
    output logic signed [skf_pkg::DATA_W-1:0] o_estimate,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [skf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [skf_pkg::DATA_W-1:0]        i_cfg_data
);
    import skf_pkg::*;

    localparam int A_W = 34;
    localparam int B_W = FRAC_BITS + 2;
    localparam int PW  = A_W + B_W;
    localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_DEN, S_DIV, S_MUL1, S_EST, S_VAR
    } t_state;

    t_state r_state;

    logic [31:0]          r_init_est;
    logic [31:0]          r_init_var;
    logic [31:0]          r_proc_noise;
    logic [31:0]          r_sens_noise;
    logic [31:0]          r_cur_est;
    logic [31:0]          r_cur_var;
    logic [31:0]          r_v;
    logic signed [32:0]   r_err;
    logic [FRAC_BITS-1:0] r_gain;
    logic                 r_den_zero;
    logic                 r_out_valid;
    logic [31:0]          r_out_est;

    logic                   meas_acc;
    logic [32:0]            var_sum;
    logic [31:0]            n_v;
    logic signed [32:0]     n_err;
    logic [32:0]            den;
    logic                   div_start;
    logic                   div_done;
    logic [FRAC_BITS:0]     div_quot;
    logic [FRAC_BITS:0]     one_m_gain;
    logic signed [A_W-1:0]  mul_a;
    logic signed [B_W-1:0]  mul_b;
    logic signed [PW-1:0]   prod;
    logic signed [PW-1:0]   prod_rnd;
    logic signed [35:0]     adj;
    logic signed [35:0]     est_wide;
    logic [31:0]            n_est;
    logic                   out_load;

    assign meas_acc = i_meas_valid && o_meas_ready;
    assign var_sum  = {1'b0, r_cur_var} + {1'b0, r_proc_noise};
    assign n_v      = var_sum[32] ? 32'hFFFF_FFFF : var_sum[31:0];
    assign n_err    = {i_measurement[31], i_measurement} - {r_cur_est[31], r_cur_est};
    assign den      = {1'b0, r_v} + {1'b0, r_sens_noise};
    assign div_start = (r_state == S_DEN);

    assign one_m_gain = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, r_gain};

    always_comb begin
        if (r_state == S_MUL1) begin
            mul_a = {r_err[32], r_err};
            mul_b = $signed({2'b00, r_gain});
        end else begin
            mul_a = $signed({2'b00, r_v});
            mul_b = $signed({1'b0, one_m_gain});
        end
    end

    skf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_v),
        .i_den   (den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    skf_mul #(.A_W(A_W), .B_W(B_W)) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign prod_rnd = prod + HALF;
    assign adj      = prod_rnd[FRAC_BITS+35:FRAC_BITS];
    assign est_wide = {{4{r_cur_est[31]}}, r_cur_est} + adj;

    always_comb begin
        if (est_wide[35:31] == 5'b00000 || est_wide[35:31] == 5'b11111) begin
            n_est = est_wide[31:0];
        end else if (est_wide[35]) begin
            n_est = 32'h8000_0000;
        end else begin
            n_est = 32'h7FFF_FFFF;
        end
    end

    assign out_load = (r_state == S_VAR) && (!r_out_valid || i_est_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_init_est   <= RST_INIT_EST;
            r_init_var   <= RST_INIT_VAR;
            r_proc_noise <= RST_PROC_NOISE;
            r_sens_noise <= RST_SENS_NOISE;
            r_cur_est    <= RST_INIT_EST;
            r_cur_var    <= RST_INIT_VAR;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_INIT_EST: begin
                        r_init_est <= i_cfg_data;
                        r_cur_est  <= i_cfg_data;
                        r_cur_var  <= r_init_var;
                    end
                    REG_INIT_VAR: begin
                        r_init_var <= i_cfg_data;
                        r_cur_var  <= i_cfg_data;
                        r_cur_est  <= r_init_est;
                    end
                    REG_PROC_NOISE: r_proc_noise <= i_cfg_data;
                    REG_SENS_NOISE: r_sens_noise <= i_cfg_data;
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_est_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (meas_acc) begin
                        r_v     <= n_v;
                        r_err   <= n_err;
                        r_state <= S_DEN;
                    end
                end
                S_DEN: begin
                    r_den_zero <= (den == '0);
                    r_state    <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        if (r_den_zero) begin
                            r_gain <= '0;
                        end else if (div_quot[FRAC_BITS]) begin
                            r_gain <= '1;
                        end else begin
                            r_gain <= div_quot[FRAC_BITS-1:0];
                        end
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_state <= S_EST;
                end
                S_EST: begin
                    r_cur_est <= n_est;
                    r_state   <= S_VAR;
                end
                S_VAR: begin
                    if (out_load) begin
                        r_cur_var <= prod[FRAC_BITS+31:FRAC_BITS];
                        r_out_est <= r_cur_est;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_meas_ready = (r_state == S_IDLE);
    assign o_est_valid  = r_out_valid;
    assign o_estimate   = r_out_est;
    assign o_cfg_ready  = 1'b1;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        meas_acc |=> !o_meas_ready)
        else $error("measurement taken while a request is in progress");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the division step");

    a_zero_den_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL1 && r_den_zero) |-> (r_gain == '0))
        else $error("nonzero gain with a zero denominator");

    a_out_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_est_valid && i_est_ready && !out_load) |=> !o_est_valid)
        else $error("estimate still valid after it was taken");

endmodule

// File: rtl/skf_div.sv
// Restoring serial divider that forms the gain quotient one bit per cycle.
// Depends on skf_pkg for the default fraction width.
module skf_div #(
    parameter int FRAC_BITS = skf_pkg::SKF_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [31:0]          i_num,
    input  logic [32:0]          i_den,
    output logic                 o_done,
    output logic [FRAC_BITS:0]   o_quot
);
    import skf_pkg::*;

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic [34:0]        r_rem;
    logic [32:0]        r_den;
    logic [FRAC_BITS:0] r_quot;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    logic        ge;
    logic [34:0] diff;
    logic [34:0] n_rem;

    assign ge    = r_rem >= {2'b00, r_den};
    assign diff  = r_rem - {2'b00, r_den};
    assign n_rem = ge ? diff : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= {3'b000, i_num};
                r_den  <= i_den;
                r_cnt  <= CNT_W'(FRAC_BITS);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_quot <= {r_quot[FRAC_BITS-1:0], ge};
                r_rem  <= {n_rem[33:0], 1'b0};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: rtl/skf_mul.sv
// Shared signed multiplier with a registered product.
// Depends on skf_pkg; used for both the estimate and the variance update.
module skf_mul #(
    parameter int A_W = 34,
    parameter int B_W = 18
) (
    input  logic                       i_clk,
    input  logic signed [A_W-1:0]      i_a,
    input  logic signed [B_W-1:0]      i_b,
    output logic signed [A_W+B_W-1:0]  o_prod
);
    import skf_pkg::*;

    logic signed [A_W+B_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule
